// ===== design/wmpz_pkg.sv =====
package wmpz_pkg;

  localparam int unsigned LIMB_W     = 32;
  localparam int unsigned MUL_LAT    = 5;
  localparam int unsigned PZ_W       = 24;
  localparam int unsigned W_MASS_W   = 12;
  localparam logic [W_MASS_W-1:0] W_MASS_RST = 12'd1286;

endpackage

// ===== design/wmpz_dly.sv =====
module wmpz_dly #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

// ===== design/wmpz_mul.sv =====
module wmpz_mul #(
  parameter int unsigned AW = 8,
  parameter int unsigned BW = 8
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);
  import wmpz_pkg::*;

  localparam int unsigned NA  = (AW + LIMB_W - 1) / LIMB_W;
  localparam int unsigned NB  = (BW + LIMB_W - 1) / LIMB_W;
  localparam int unsigned AXW = NA * LIMB_W;
  localparam int unsigned BXW = NB * LIMB_W;
  localparam int unsigned RW  = BXW + LIMB_W;
  localparam int unsigned SW  = AXW + BXW;
  localparam int unsigned PW  = AW + BW;

  // five stages: magnitudes, limb products, row sums, total, sign
  logic [AXW-1:0]      ma_q;
  logic [BXW-1:0]      mb_q;
  logic [4:1]          neg_q;
  logic [2*LIMB_W-1:0] pp_q [NA][NB];
  logic [RW-1:0]       row_d [NA];
  logic [RW-1:0]       row_q [NA];
  logic [SW-1:0]       sum_d, sum_q;
  logic [PW-1:0]       p_q;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (RW'(pp_q[i][j]) << (j * LIMB_W));
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (SW'(row_q[i]) << (i * LIMB_W));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q  <= AXW'($unsigned(a_i[AW-1] ? -a_i : a_i));
      mb_q  <= BXW'($unsigned(b_i[BW-1] ? -b_i : b_i));
      neg_q <= {neg_q[3:1], a_i[AW-1] ^ b_i[BW-1]};
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= (2*LIMB_W)'(ma_q[i*LIMB_W +: LIMB_W]) *
                        (2*LIMB_W)'(mb_q[j*LIMB_W +: LIMB_W]);
        end
      end
      row_q <= row_d;
      sum_q <= sum_d;
      p_q   <= neg_q[4] ? -sum_q[PW-1:0] : sum_q[PW-1:0];
    end
  end

  assign p_o = $signed(p_q);

endmodule

// ===== design/wmpz_sqrt.sv =====
module wmpz_sqrt #(
  parameter int unsigned RW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] d_i,
  output logic [RW-1:0]   s_o
);

  localparam int unsigned DW = 2 * RW;
  localparam int unsigned MW = RW + 2;

  logic [DW-1:0] d_q [RW];
  logic [MW-1:0] r_q [RW];
  logic [RW-1:0] s_q [RW];

  // one root bit per stage
  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [DW-1:0] d_in;
    logic [MW-1:0] r_in, r_sh, trial;
    logic [RW-1:0] s_in;

    if (g == 0) begin : g_first
      assign d_in = d_i;
      assign r_in = '0;
      assign s_in = '0;
    end else begin : g_next
      assign d_in = d_q[g-1];
      assign r_in = r_q[g-1];
      assign s_in = s_q[g-1];
    end

    assign r_sh  = {r_in[MW-3:0], d_in[DW-1 -: 2]};
    assign trial = {s_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[g] <= d_in << 2;
        if (r_sh >= trial) begin
          r_q[g] <= r_sh - trial;
          s_q[g] <= {s_in[RW-2:0], 1'b1};
        end else begin
          r_q[g] <= r_sh;
          s_q[g] <= {s_in[RW-2:0], 1'b0};
        end
      end
    end
  end

  assign s_o = s_q[RW-1];

endmodule

// ===== design/wmpz_div.sv =====
module wmpz_div #(
  parameter int unsigned NW  = 16,
  parameter int unsigned DVW = 8,
  parameter int unsigned QW  = 8
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [NW-1:0]  n_i,
  input  logic [DVW-1:0] dv_i,
  output logic [QW-1:0]  q_o
);

  // low QW quotient bits only; caller flags n >= dv << QW
  logic [DVW-1:0] r_q [QW];
  logic [QW-1:0]  l_q [QW];
  logic [DVW-1:0] v_q [QW];
  logic [QW-1:0]  q_q [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DVW-1:0] r_in, v_in;
    logic [QW-1:0]  l_in, q_in;
    logic [DVW:0]   t;

    if (g == 0) begin : g_first
      assign r_in = DVW'(n_i >> QW);
      assign l_in = n_i[QW-1:0];
      assign v_in = dv_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[g-1];
      assign l_in = l_q[g-1];
      assign v_in = v_q[g-1];
      assign q_in = q_q[g-1];
    end

    assign t = {r_in, l_in[QW-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        l_q[g] <= l_in << 1;
        v_q[g] <= v_in;
        if (t >= {1'b0, v_in}) begin
          r_q[g] <= DVW'(t - {1'b0, v_in});
          q_q[g] <= {q_in[QW-2:0], 1'b1};
        end else begin
          r_q[g] <= DVW'(t);
          q_q[g] <= {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = q_q[QW-1];

endmodule

// ===== design/w_mass_neutrino_pz_solver.sv =====
// Neutrino pz from the W mass constraint. Takes one event per clock unless
// stalled and returns the root of smaller magnitude of a*pz^2 + b*pz + c = 0,
// rounded to nearest, with complex, saturated and invalid flags. The square
// root resolves one bit per stage and the divider one quotient bit per stage.
// The input stalls only while a result waits in the one-entry skid behind the
// output register. Write w_mass only while the block is empty.
module w_mass_neutrino_pz_solver #(
  parameter int unsigned MOMENTUM_WIDTH = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wmpz_pkg::W_MASS_W-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [MOMENTUM_WIDTH-2:0]           lepton_energy_i,
  input  logic signed [MOMENTUM_WIDTH-1:0]    lepton_px_i,
  input  logic signed [MOMENTUM_WIDTH-1:0]    lepton_py_i,
  input  logic signed [MOMENTUM_WIDTH-1:0]    lepton_pz_i,
  input  logic signed [MOMENTUM_WIDTH-1:0]    neutrino_px_i,
  input  logic signed [MOMENTUM_WIDTH-1:0]    neutrino_py_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wmpz_pkg::PZ_W-1:0]    neutrino_pz_o,
  output logic                                complex_flag_o,
  output logic                                saturated_flag_o,
  output logic                                invalid_flag_o
);
  import wmpz_pkg::*;

  localparam int unsigned W    = MOMENTUM_WIDTH;
  localparam int unsigned KW   = 2*W + 3;
  localparam int unsigned BPW  = W + KW;
  localparam int unsigned C4W  = 4*W + 5;
  localparam int unsigned PPW  = 2*KW;
  localparam int unsigned DFW  = KW + C4W;
  localparam int unsigned RW   = 3*W + 2;
  localparam int unsigned NUMW = 3*W + 4;
  localparam int unsigned AMW  = 2*W - 2;
  localparam int unsigned DVW  = 2*W - 1;
  localparam int unsigned NV   = 9 + 3*MUL_LAT + RW + PZ_W;
  localparam logic [PZ_W-1:0] LIM_POS = {1'b0, {(PZ_W-1){1'b1}}};
  localparam logic [PZ_W-1:0] LIM_NEG = {1'b1, {(PZ_W-1){1'b0}}};

  typedef struct packed {
    logic signed [BPW-1:0] b;
    logic signed [KW-1:0]  a;
    logic                  inv;
  } s3_t;

  typedef struct packed {
    logic signed [BPW-1:0] b;
    logic signed [KW-1:0]  a;
    logic                  cplx;
    logic                  inv;
  } s4_t;

  typedef struct packed {
    logic neg;
    logic cplx;
    logic inv;
    logic ovf;
  } s5_t;

  typedef struct packed {
    logic signed [PZ_W-1:0] pz;
    logic                   cplx;
    logic                   sat;
    logic                   inv;
  } res_t;

  logic [W_MASS_W-1:0] w_mass_q;
  logic [NV-1:0]       vld_q;
  logic                en;
  res_t                out_q, skid_q, res;
  logic                out_vld_q, skid_vld_q, take;

  // p0 / p1
  logic [W-2:0]        e0_q;
  logic signed [W-1:0] lx0_q, ly0_q, lz0_q, nx0_q, ny0_q;
  logic signed [W-1:0] e1_q, lz1_q, nx1_q, ny1_q;
  logic signed [W:0]   sx1_q, sy1_q;

  // first products
  logic signed [2*W-1:0]        e2_w, nx2_w, ny2_w, lz2_w;
  logic signed [2*W+1:0]        sx2_w, sy2_w;
  logic signed [2*W_MASS_W+1:0] m2_w;
  logic signed [W-1:0]          lz_m1;

  // q1 / q2
  logic signed [KW-1:0] nt2q1_q, uq1_q, vq1_q, aq1_q, e2q1_q;
  logic signed [W-1:0]  lzq1_q, lzq2_q;
  logic signed [KW-1:0] k2_q, nt2q2_q, e2q2_q, aq2_q;

  // second products
  logic signed [BPW-1:0] b_w;
  logic signed [PPW-1:0] kk_w, ne_w;
  logic signed [KW-1:0]  a_m2;

  // r1
  logic signed [C4W-1:0] c4_q;
  s3_t                   s3_q, s3_d;

  // third products
  logic signed [2*BPW-1:0] bb_w;
  logic signed [DFW-1:0]   ac_w, dfull;

  // s1
  logic [2*RW-1:0] dsq_q;
  s4_t             s4_q, s4_d;
  logic [RW-1:0]   root_w;

  // t1..t3
  logic signed [NUMW-1:0] bn, sn, num_q;
  logic                   bpos;
  logic signed [KW-1:0]   a5_q, a6_q;
  logic                   cplx5_q, inv5_q, neg6_q, cplx6_q, inv6_q;
  logic [NUMW-1:0]        mag6_q, n7_q;
  logic [DVW-1:0]         dv7_q;
  logic                   neg7_q, cplx7_q, inv7_q, ovf7;
  s5_t                    s5_in, s5_d;

  logic [PZ_W-1:0] q_w, lim, pzm;
  logic            sat;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_mass_q <= W_MASS_RST;
    end else if (cfg_we_i) begin
      w_mass_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e0_q  <= lepton_energy_i;
      lx0_q <= lepton_px_i;
      ly0_q <= lepton_py_i;
      lz0_q <= lepton_pz_i;
      nx0_q <= neutrino_px_i;
      ny0_q <= neutrino_py_i;

      e1_q  <= $signed({1'b0, e0_q});
      sx1_q <= (W+1)'(lx0_q) + (W+1)'(nx0_q);
      sy1_q <= (W+1)'(ly0_q) + (W+1)'(ny0_q);
      lz1_q <= lz0_q;
      nx1_q <= nx0_q;
      ny1_q <= ny0_q;
    end
  end

  wmpz_mul #(.AW(W), .BW(W)) u_mul_e2 (
    .clk_i, .en_i(en), .a_i(e1_q), .b_i(e1_q), .p_o(e2_w));
  wmpz_mul #(.AW(W), .BW(W)) u_mul_nx2 (
    .clk_i, .en_i(en), .a_i(nx1_q), .b_i(nx1_q), .p_o(nx2_w));
  wmpz_mul #(.AW(W), .BW(W)) u_mul_ny2 (
    .clk_i, .en_i(en), .a_i(ny1_q), .b_i(ny1_q), .p_o(ny2_w));
  wmpz_mul #(.AW(W), .BW(W)) u_mul_lz2 (
    .clk_i, .en_i(en), .a_i(lz1_q), .b_i(lz1_q), .p_o(lz2_w));
  wmpz_mul #(.AW(W+1), .BW(W+1)) u_mul_sx2 (
    .clk_i, .en_i(en), .a_i(sx1_q), .b_i(sx1_q), .p_o(sx2_w));
  wmpz_mul #(.AW(W+1), .BW(W+1)) u_mul_sy2 (
    .clk_i, .en_i(en), .a_i(sy1_q), .b_i(sy1_q), .p_o(sy2_w));
  wmpz_mul #(.AW(W_MASS_W+1), .BW(W_MASS_W+1)) u_mul_m2 (
    .clk_i, .en_i(en), .a_i($signed({1'b0, w_mass_q})), .b_i($signed({1'b0, w_mass_q})),
    .p_o(m2_w));

  wmpz_dly #(.WIDTH(W), .DEPTH(MUL_LAT)) u_dly_lz (
    .clk_i, .en_i(en), .d_i(lz1_q), .q_o(lz_m1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nt2q1_q <= KW'(nx2_w) + KW'(ny2_w);
      uq1_q   <= KW'(sx2_w) + KW'(sy2_w);
      vq1_q   <= KW'(lz2_w) + KW'(m2_w);
      aq1_q   <= KW'(e2_w) - KW'(lz2_w);
      e2q1_q  <= KW'(e2_w);
      lzq1_q  <= lz_m1;

      k2_q    <= e2q1_q + nt2q1_q - uq1_q - vq1_q;
      nt2q2_q <= nt2q1_q;
      e2q2_q  <= e2q1_q;
      aq2_q   <= aq1_q;
      lzq2_q  <= lzq1_q;
    end
  end

  wmpz_mul #(.AW(W), .BW(KW)) u_mul_b (
    .clk_i, .en_i(en), .a_i(lzq2_q), .b_i(k2_q), .p_o(b_w));
  wmpz_mul #(.AW(KW), .BW(KW)) u_mul_kk (
    .clk_i, .en_i(en), .a_i(k2_q), .b_i(k2_q), .p_o(kk_w));
  wmpz_mul #(.AW(KW), .BW(KW)) u_mul_ne (
    .clk_i, .en_i(en), .a_i(nt2q2_q), .b_i(e2q2_q), .p_o(ne_w));

  wmpz_dly #(.WIDTH(KW), .DEPTH(MUL_LAT)) u_dly_a (
    .clk_i, .en_i(en), .d_i(aq2_q), .q_o(a_m2));

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q     <= C4W'((ne_w <<< 2) - kk_w);
      s3_q.b   <= b_w;
      s3_q.a   <= a_m2;
      s3_q.inv <= a_m2[KW-1] || (a_m2 == '0);
    end
  end

  wmpz_mul #(.AW(BPW), .BW(BPW)) u_mul_bb (
    .clk_i, .en_i(en), .a_i(s3_q.b), .b_i(s3_q.b), .p_o(bb_w));
  wmpz_mul #(.AW(KW), .BW(C4W)) u_mul_ac (
    .clk_i, .en_i(en), .a_i(s3_q.a), .b_i(c4_q), .p_o(ac_w));

  wmpz_dly #(.WIDTH($bits(s3_t)), .DEPTH(MUL_LAT)) u_dly_s3 (
    .clk_i, .en_i(en), .d_i(s3_q), .q_o(s3_d));

  assign dfull = DFW'(bb_w) - ac_w;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dsq_q     <= dfull[DFW-1] ? '0 : dfull[2*RW-1:0];
      s4_q.b    <= s3_d.b;
      s4_q.a    <= s3_d.a;
      s4_q.cplx <= dfull[DFW-1];
      s4_q.inv  <= s3_d.inv;
    end
  end

  wmpz_sqrt #(.RW(RW)) u_sqrt (
    .clk_i, .en_i(en), .d_i(dsq_q), .s_o(root_w));

  wmpz_dly #(.WIDTH($bits(s4_t)), .DEPTH(RW)) u_dly_s4 (
    .clk_i, .en_i(en), .d_i(s4_q), .q_o(s4_d));

  assign bn   = NUMW'(s4_d.b);
  assign sn   = $signed({2'b00, root_w});
  assign bpos = !s4_d.b[BPW-1] && (s4_d.b != '0);

  assign ovf7 = ({{DVW{1'b0}}, n7_q[NUMW-1:PZ_W]} >= {{(NUMW-PZ_W){1'b0}}, dv7_q});

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (s4_d.cplx) begin
        num_q <= -bn;
      end else if (bpos) begin
        num_q <= sn - bn;
      end else begin
        num_q <= -bn - sn;
      end
      a5_q    <= s4_d.a;
      cplx5_q <= s4_d.cplx;
      inv5_q  <= s4_d.inv;

      neg6_q  <= num_q[NUMW-1];
      mag6_q  <= $unsigned(num_q[NUMW-1] ? -num_q : num_q);
      a6_q    <= a5_q;
      cplx6_q <= cplx5_q;
      inv6_q  <= inv5_q;

      n7_q    <= mag6_q + NUMW'(a6_q[AMW-1:0]);
      dv7_q   <= {a6_q[AMW-1:0], 1'b0};
      neg7_q  <= neg6_q;
      cplx7_q <= cplx6_q;
      inv7_q  <= inv6_q;
    end
  end

  assign s5_in = '{neg: neg7_q, cplx: cplx7_q, inv: inv7_q, ovf: ovf7};

  wmpz_div #(.NW(NUMW), .DVW(DVW), .QW(PZ_W)) u_div (
    .clk_i, .en_i(en), .n_i(n7_q), .dv_i(dv7_q), .q_o(q_w));

  wmpz_dly #(.WIDTH($bits(s5_t)), .DEPTH(PZ_W)) u_dly_s5 (
    .clk_i, .en_i(en), .d_i(s5_in), .q_o(s5_d));

  assign lim = s5_d.neg ? LIM_NEG : LIM_POS;
  assign sat = s5_d.ovf || (q_w > lim);
  assign pzm = sat ? lim : q_w;

  always_comb begin
    if (s5_d.inv) begin
      res = '{pz: '0, cplx: 1'b0, sat: 1'b0, inv: 1'b1};
    end else begin
      res.pz   = $signed(s5_d.neg ? -pzm : pzm);
      res.cplx = s5_d.cplx;
      res.sat  = sat;
      res.inv  = 1'b0;
    end
  end

  // output register with one-entry skid
  assign take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_q[NV-1]) begin
      if (out_vld_q && !take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_q[NV-1]) begin
      if (out_vld_q && !take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o      = out_vld_q;
  assign neutrino_pz_o    = out_q.pz;
  assign complex_flag_o   = out_q.cplx;
  assign saturated_flag_o = out_q.sat;
  assign invalid_flag_o   = out_q.inv;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid beat without output beat");

  a_pipe_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |=> $stable(vld_q))
    else $error("pipeline moved while skid full");

  a_invalid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.inv |-> out_q.pz == '0 && !out_q.cplx && !out_q.sat)
    else $error("invalid beat carries result bits");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !skid_vld_q && !vld_q[NV-1] |=> !out_vld_q)
    else $error("output beat repeated");

endmodule

// ===== tb/w_mass_neutrino_pz_solver_tb.sv =====
module w_mass_neutrino_pz_solver_tb;
  import wmpz_pkg::*;

  localparam int MW = 20;
  localparam int DRAIN_CYCLES = 150;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [MW-2:0]        energy;
    logic signed [MW-1:0] lx, ly, lz, nx, ny;
  } event_t;

  typedef struct {
    logic [PZ_W-1:0] pz;
    logic            cplx, sat, inval;
  } pz_result_t;

  class pz_scoreboard;
    pz_result_t pending[$];
    int         errors = 0;

    function automatic wide_t isqrt(wide_t n);
      logic [255:0] rem, res, bitv;
      rem  = n;
      res  = '0;
      bitv = 256'd1 << 254;
      for (int i = 0; i < 128; i++) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function automatic pz_result_t solve_pz(event_t ev, logic [W_MASS_W-1:0] mass);
      wide_t e, lx, ly, lz, nx, ny, m, e2, nt2, sx, sy, k, a, b, c4, d, num, mag, q, lim;
      pz_result_t r;
      logic neg;
      e = {237'd0, ev.energy};
      lx = ev.lx; ly = ev.ly; lz = ev.lz; nx = ev.nx; ny = ev.ny;
      m = {244'd0, mass};
      r = '{pz: '0, cplx: 1'b0, sat: 1'b0, inval: 1'b0};
      e2  = e * e;
      nt2 = nx * nx + ny * ny;
      sx  = lx + nx;
      sy  = ly + ny;
      k   = e2 + nt2 - sx * sx - sy * sy - lz * lz - m * m;
      a   = e2 - lz * lz;
      if (a <= 0) begin
        r.inval = 1'b1;
        return r;
      end
      b  = lz * k;
      c4 = 4 * nt2 * e2 - k * k;
      d  = b * b - a * c4;
      if (d < 0) begin
        num = -b;
        r.cplx = 1'b1;
      end else if (b > 0) begin
        num = isqrt(d) - b;
      end else begin
        num = -b - isqrt(d);
      end
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (mag + a) / (2 * a);
      lim = neg ? 256'd8388608 : 256'd8388607;
      if (q > lim) begin
        r.sat = 1'b1;
        q = lim;
      end
      if (neg) q = -q;
      r.pz = q[PZ_W-1:0];
      return r;
    endfunction

    function void note_event(event_t ev, logic [W_MASS_W-1:0] mass);
      pending.push_back(solve_pz(ev, mass));
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(pz_result_t got);
      pz_result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected beat pz=%0d", $signed(got.pz)));
        return;
      end
      exp = pending.pop_front();
      if (got.pz !== exp.pz)
        report($sformatf("pz got %0d exp %0d", $signed(got.pz), $signed(exp.pz)));
      if (got.cplx !== exp.cplx)
        report($sformatf("complex got %b exp %b", got.cplx, exp.cplx));
      if (got.sat !== exp.sat)
        report($sformatf("saturated got %b exp %b", got.sat, exp.sat));
      if (got.inval !== exp.inval)
        report($sformatf("invalid got %b exp %b", got.inval, exp.inval));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [W_MASS_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [MW-2:0] lepton_energy_i = '0;
  logic signed [MW-1:0] lepton_px_i = '0, lepton_py_i = '0, lepton_pz_i = '0;
  logic signed [MW-1:0] neutrino_px_i = '0, neutrino_py_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [PZ_W-1:0] neutrino_pz_o;
  logic complex_flag_o, saturated_flag_o, invalid_flag_o;

  w_mass_neutrino_pz_solver #(.MOMENTUM_WIDTH(MW)) DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pz_scoreboard sb = new();
  logic [W_MASS_W-1:0] mass_shadow = W_MASS_RST;
  int accepted = 0;
  int stall_mode = 0;
  int hold_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_event('{energy: lepton_energy_i, lx: lepton_px_i, ly: lepton_py_i,
                      lz: lepton_pz_i, nx: neutrino_px_i, ny: neutrino_py_i}, mass_shadow);
      accepted++;
    end
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{pz: neutrino_pz_o, cplx: complex_flag_o,
                        sat: saturated_flag_o, inval: invalid_flag_o});
  end

  // receiver stall pattern, with a long hold-off while hold_cycles is set
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 1) == 0);
        default: out_stall_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_beat(event_t ev);
    int n;
    lepton_energy_i = ev.energy;
    lepton_px_i = ev.lx;
    lepton_py_i = ev.ly;
    lepton_pz_i = ev.lz;
    neutrino_px_i = ev.nx;
    neutrino_py_i = ev.ny;
    in_valid_i = 1'b1;
    n = accepted;
    do @(negedge clk_i); while (accepted == n);
  endtask

  task automatic idle(int cycles);
    in_valid_i = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mass(logic [W_MASS_W-1:0] m);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = m;
    mass_shadow = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic event_t random_event();
    event_t ev;
    int scale, mag;
    ev.lx = MW'($urandom); ev.ly = MW'($urandom); ev.lz = MW'($urandom);
    ev.nx = MW'($urandom); ev.ny = MW'($urandom); ev.energy = (MW-1)'($urandom);
    if ($urandom_range(0, 9) < 7) begin
      scale = $urandom_range(4, 18);
      ev.lx = $signed(ev.lx) >>> (MW - scale);
      ev.ly = $signed(ev.ly) >>> (MW - scale);
      ev.lz = $signed(ev.lz) >>> (MW - scale);
      ev.nx = $signed(ev.nx) >>> (MW - scale);
      ev.ny = $signed(ev.ny) >>> (MW - scale);
      mag = (ev.lx < 0 ? -ev.lx : ev.lx) + (ev.ly < 0 ? -ev.ly : ev.ly)
          + (ev.lz < 0 ? -ev.lz : ev.lz) + $urandom_range(0, 1 << (scale - 2));
      ev.energy = (mag > 524287) ? 19'h7FFFF : mag[MW-2:0];
    end
    return ev;
  endfunction

  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      stall_mode = $urandom_range(0, 3);
      repeat ($urandom_range(1, 20)) begin
        if (sent < count) begin
          send_beat(random_event());
          sent++;
        end
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 8));
    end
  endtask

  event_t directed[$];

  initial begin
    directed.push_back('{19'd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0});
    directed.push_back('{19'h7FFFF, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0});
    directed.push_back('{19'd100, 20'sd0, 20'sd0, 20'sd200, 20'sd5, 20'sd5});
    directed.push_back('{19'h7FFFF, -20'sd524288, -20'sd524288, -20'sd524288,
                         -20'sd524288, -20'sd524288});
    directed.push_back('{19'h7FFFF, 20'sd524287, 20'sd524287, 20'sd524287,
                         20'sd524287, 20'sd524287});
    directed.push_back('{19'h7FFFF, 20'sd0, 20'sd0, 20'sd524286, 20'sd300000, 20'sd0});
    directed.push_back('{19'h7FFFF, 20'sd0, 20'sd0, -20'sd524286, 20'sd0, -20'sd300000});
    directed.push_back('{19'd1000, 20'sd600, 20'sd0, 20'sd800, 20'sd700, 20'sd0});
    directed.push_back('{19'd640, 20'sd640, 20'sd0, 20'sd0, -20'sd640, 20'sd0});
    directed.push_back('{19'd2000, 20'sd100, 20'sd50, 20'sd1500, -20'sd400, 20'sd300});
    directed.push_back('{19'd2000, 20'sd100, 20'sd50, -20'sd1500, 20'sd400, -20'sd300});
    directed.push_back('{19'd1, 20'sd0, 20'sd0, 20'sd0, 20'sd0, 20'sd0});
    directed.push_back('{19'd5000, 20'sd3000, -20'sd2000, 20'sd100, 20'sd10, 20'sd10});
    directed.push_back('{19'h55555, 20'sh55555, 20'shAAAAA, 20'sh0F0F0, 20'shF0F0F, 20'sh33333});

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    stall_mode = 1;
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // long receiver hold-off while input keeps coming
    hold_cycles = 400;
    stall_mode = 0;
    repeat (40) send_beat(random_event());
    random_phase(120);
    drain();

    write_mass(12'd0);
    foreach (directed[i]) send_beat(directed[i]);
    random_phase(150);
    drain();

    write_mass(12'hFFF);
    foreach (directed[i]) send_beat(directed[i]);
    random_phase(150);
    drain();

    write_mass(W_MASS_W'($urandom_range(0, 4095)));
    random_phase(150);
    drain();

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
